// ----- hdl/tcp_option_parser_assert.svh -----
// Assertion macros used by the option parser back stage.
// Each check is sampled on the rising edge of clk and is off while rst_n is low.
`ifndef TCP_OPTION_PARSER_ASSERT_SVH
`define TCP_OPTION_PARSER_ASSERT_SVH

`ifndef SYNTHESIS

// The property must hold at every sampled edge.
`define TOP_ASSERT(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// The expression must never be true.
`define TOP_ASSERT_NEVER(label, expr, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) else $error(msg);

`else

`define TOP_ASSERT(label, prop, msg)
`define TOP_ASSERT_NEVER(label, expr, msg)

`endif

`endif

// ----- hdl/tcpop_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none

package tcpop_pkg;

    // option kinds
    localparam logic [7:0] KIND_EOL = 8'd0;
    localparam logic [7:0] KIND_NOP = 8'd1;
    localparam logic [7:0] KIND_MSS = 8'd2;
    localparam logic [7:0] KIND_WS  = 8'd3;
    localparam logic [7:0] KIND_TS  = 8'd8;

    // number of kinds tracked in the bitmap
    localparam int KIND_LIMIT = 16;
    localparam int KIND_IDX_W = $clog2(KIND_LIMIT);

    // found flag bit positions
    localparam int FOUND_MSS = 0;
    localparam int FOUND_WS  = 1;
    localparam int FOUND_TS  = 2;

    localparam logic [15:0] RESET_MSS = 16'd536;

    // queue between front and back
    localparam int QDEPTH  = 4;
    localparam int QPTR_W  = $clog2(QDEPTH);
    localparam int QCNT_W  = $clog2(QDEPTH + 1);

    typedef enum logic [1:0] {
        PH_KIND,
        PH_LEN,
        PH_BODY
    } phase_t;

    // one classified option byte
    typedef struct packed {
        logic [7:0]            opt_byte;
        logic                  last;
        logic                  is_eol;
        logic                  is_nop;
        logic [KIND_LIMIT-1:0] kind_onehot;
    } q_entry_t;

    typedef struct packed {
        logic [15:0] kinds_seen;
        logic [15:0] mss;
        logic        mss_found;
        logic [7:0]  window_scale;
        logic        ts_found;
        logic [31:0] ts_value;
        logic [31:0] ts_echo;
        logic        malformed;
    } result_t;

    function automatic logic [2:0] found_bit(input logic [7:0] kind);
        logic [2:0] fb;
        fb = 3'b000;
        if (kind == KIND_MSS) fb[FOUND_MSS] = 1'b1;
        if (kind == KIND_WS)  fb[FOUND_WS]  = 1'b1;
        if (kind == KIND_TS)  fb[FOUND_TS]  = 1'b1;
        return fb;
    endfunction

    function automatic logic [7:0] wanted_len(input logic [7:0] kind);
        logic [7:0] len;
        len = 8'd0;
        if (kind == KIND_MSS) len = 8'd4;
        if (kind == KIND_WS)  len = 8'd3;
        if (kind == KIND_TS)  len = 8'd10;
        return len;
    endfunction

endpackage

`default_nettype wire

// ----- hdl/tcpop_front.sv -----
`timescale 1ns / 1ps
`default_nettype none

// Classifies incoming bytes and queues them for the parser.
module tcpop_front (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               in_valid,
    output logic                    in_stall,
    input  wire logic [7:0]         opt_byte,
    input  wire logic               last,
    input  wire logic               q_pop,
    output logic                    q_valid,
    output tcpop_pkg::q_entry_t     q_entry
);
    import tcpop_pkg::*;

    q_entry_t          q_mem_reg [QDEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QCNT_W-1:0] count_reg, count_next;
    q_entry_t          cls;
    logic              push;
    logic              pop;

    // byte classification
    always_comb
    begin
        cls.opt_byte    = opt_byte;
        cls.last        = last;
        cls.is_eol      = (opt_byte == KIND_EOL);
        cls.is_nop      = (opt_byte == KIND_NOP);
        cls.kind_onehot = '0;
        if (opt_byte < 8'(KIND_LIMIT))
        begin
            cls.kind_onehot[opt_byte[KIND_IDX_W-1:0]] = 1'b1;
        end
    end

    assign in_stall = (count_reg == QCNT_W'(QDEPTH));
    assign q_valid  = (count_reg != '0);
    assign q_entry  = q_mem_reg[rd_ptr_reg];
    assign push     = in_valid && !in_stall;
    assign pop      = q_pop && q_valid;

    always_comb
    begin
        wr_ptr_next = push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            q_mem_reg[wr_ptr_reg] <= cls;
        end
    end

endmodule

`default_nettype wire

// ----- hdl/tcpop_back.sv -----
`timescale 1ns / 1ps
`default_nettype none

`include "tcp_option_parser_assert.svh"

// Option parser state machine and result register.
module tcpop_back (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                q_valid,
    input  wire tcpop_pkg::q_entry_t q_entry,
    output logic                     q_pop,
    input  wire logic [15:0]         default_mss,
    output logic                     out_valid,
    input  wire logic                out_stall,
    output tcpop_pkg::result_t       result
);
    import tcpop_pkg::*;

    phase_t      phase_reg, phase_next;
    logic [7:0]  cur_kind_reg, cur_kind_next;
    logic [7:0]  body_left_reg, body_left_next;
    logic [3:0]  body_index_reg, body_index_next;
    logic [15:0] bitmap_reg, bitmap_next;
    logic [15:0] mss_acc_reg, mss_acc_next;
    logic [7:0]  ws_acc_reg, ws_acc_next;
    logic [31:0] tsval_acc_reg, tsval_acc_next;
    logic [31:0] tsecr_acc_reg, tsecr_acc_next;
    logic [2:0]  found_reg, found_next;
    logic        bad_reg, bad_next;
    logic        ended_reg, ended_next;
    logic        out_valid_reg, out_valid_next;
    result_t     result_reg, result_next;

    logic        out_free;
    logic        take;
    logic [7:0]  b;
    logic [7:0]  want;
    logic [2:0]  fb;

    assign out_free  = !out_valid_reg || !out_stall;
    // a final byte waits until the result register can take its summary
    assign q_pop     = q_valid && (!q_entry.last || out_free);
    assign take      = q_pop;
    assign out_valid = out_valid_reg;
    assign result    = result_reg;
    assign b         = q_entry.opt_byte;
    assign want      = wanted_len(cur_kind_reg);
    assign fb        = found_bit(cur_kind_reg);

    always_comb
    begin
        phase_next      = phase_reg;
        cur_kind_next   = cur_kind_reg;
        body_left_next  = body_left_reg;
        body_index_next = body_index_reg;
        bitmap_next     = bitmap_reg;
        mss_acc_next    = mss_acc_reg;
        ws_acc_next     = ws_acc_reg;
        tsval_acc_next  = tsval_acc_reg;
        tsecr_acc_next  = tsecr_acc_reg;
        found_next      = found_reg;
        bad_next        = bad_reg;
        ended_next      = ended_reg;

        if (!ended_reg)
        begin
            case (phase_reg)
                PH_KIND:
                begin
                    if (q_entry.is_eol)
                    begin
                        ended_next = 1'b1;
                    end
                    else if (!q_entry.is_nop)
                    begin
                        bitmap_next   = bitmap_reg | q_entry.kind_onehot;
                        cur_kind_next = b;
                        phase_next    = PH_LEN;
                    end
                end
                PH_LEN:
                begin
                    if (q_entry.is_eol || q_entry.is_nop)
                    begin
                        // length below two: stop parsing
                        bad_next      = 1'b1;
                        ended_next    = 1'b1;
                        cur_kind_next = '0;
                        phase_next    = PH_KIND;
                    end
                    else
                    begin
                        if (want != '0 && b != want)
                        begin
                            bad_next      = 1'b1;
                            cur_kind_next = '0;
                        end
                        else if (want == '0)
                        begin
                            cur_kind_next = '0;
                        end
                        body_left_next  = b - 8'd2;
                        body_index_next = '0;
                        phase_next      = (b == 8'd2) ? PH_KIND : PH_BODY;
                    end
                end
                PH_BODY:
                begin
                    if (fb != '0 && (found_reg & fb) == '0)
                    begin
                        if (cur_kind_reg == KIND_MSS)
                        begin
                            mss_acc_next = {mss_acc_reg[7:0], b};
                        end
                        else if (cur_kind_reg == KIND_WS)
                        begin
                            ws_acc_next = b;
                        end
                        else if (body_index_reg < 4'd4)
                        begin
                            tsval_acc_next = {tsval_acc_reg[23:0], b};
                        end
                        else
                        begin
                            tsecr_acc_next = {tsecr_acc_reg[23:0], b};
                        end
                    end
                    if (body_index_reg != 4'd15)
                    begin
                        body_index_next = body_index_reg + 4'd1;
                    end
                    body_left_next = body_left_reg - 8'd1;
                    if (body_left_reg == 8'd1)
                    begin
                        found_next    = found_reg | fb;
                        cur_kind_next = '0;
                        phase_next    = PH_KIND;
                    end
                end
                default:
                begin
                    phase_next = PH_KIND;
                end
            endcase
        end
    end

    // summary built from the state after the final byte
    always_comb
    begin
        result_next.kinds_seen   = bitmap_next;
        result_next.mss_found    = found_next[FOUND_MSS];
        result_next.mss          = found_next[FOUND_MSS] ? mss_acc_next : default_mss;
        result_next.window_scale = found_next[FOUND_WS] ? ws_acc_next : 8'd0;
        result_next.ts_found     = found_next[FOUND_TS];
        result_next.ts_value     = found_next[FOUND_TS] ? tsval_acc_next : 32'd0;
        result_next.ts_echo      = found_next[FOUND_TS] ? tsecr_acc_next : 32'd0;
        // truncated option also counts as malformed
        result_next.malformed    = bad_next || (!ended_next && phase_next != PH_KIND);
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (take && q_entry.last)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg      <= PH_KIND;
            cur_kind_reg   <= '0;
            body_left_reg  <= '0;
            body_index_reg <= '0;
            bitmap_reg     <= '0;
            mss_acc_reg    <= '0;
            ws_acc_reg     <= '0;
            tsval_acc_reg  <= '0;
            tsecr_acc_reg  <= '0;
            found_reg      <= '0;
            bad_reg        <= 1'b0;
            ended_reg      <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            if (take)
            begin
                if (q_entry.last)
                begin
                    phase_reg      <= PH_KIND;
                    cur_kind_reg   <= '0;
                    body_left_reg  <= '0;
                    body_index_reg <= '0;
                    bitmap_reg     <= '0;
                    mss_acc_reg    <= '0;
                    ws_acc_reg     <= '0;
                    tsval_acc_reg  <= '0;
                    tsecr_acc_reg  <= '0;
                    found_reg      <= '0;
                    bad_reg        <= 1'b0;
                    ended_reg      <= 1'b0;
                end
                else
                begin
                    phase_reg      <= phase_next;
                    cur_kind_reg   <= cur_kind_next;
                    body_left_reg  <= body_left_next;
                    body_index_reg <= body_index_next;
                    bitmap_reg     <= bitmap_next;
                    mss_acc_reg    <= mss_acc_next;
                    ws_acc_reg     <= ws_acc_next;
                    tsval_acc_reg  <= tsval_acc_next;
                    tsecr_acc_reg  <= tsecr_acc_next;
                    found_reg      <= found_next;
                    bad_reg        <= bad_next;
                    ended_reg      <= ended_next;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (take && q_entry.last)
        begin
            result_reg <= result_next;
        end
    end

    `TOP_ASSERT_NEVER(a_no_overwrite, q_pop && q_entry.last && out_valid_reg && out_stall, "result overwritten while stalled")
    `TOP_ASSERT(a_clear_after_last, q_pop && q_entry.last |=> phase_reg == PH_KIND && !ended_reg && found_reg == 3'b000, "state not cleared after final byte")
    `TOP_ASSERT(a_body_nonzero, phase_reg == PH_BODY |-> body_left_reg != 8'd0, "body phase with no bytes left")
    `TOP_ASSERT(a_mss_kind_seen, out_valid_reg && result_reg.mss_found |-> result_reg.kinds_seen[2], "MSS found without its kind bit")

endmodule

`default_nettype wire

// ----- hdl/tcp_option_parser.sv -----
`timescale 1ns / 1ps
`default_nettype none

// TCP option parser. Takes the option area one byte per item, with last set on the
// final byte, and gives one summary item per option area: a bitmap of option kinds
// below 16, the first valid MSS (or default_mss when none), window scale, timestamp
// value and echo, found flags and a malformed flag. NOP bytes are skipped, EOL ends
// parsing, and a short length, a wrong length on a known kind or an option cut off by
// the final byte sets malformed. It takes one byte per cycle unless out_stall holds
// the result register. A front stage classifies each byte into a four-entry queue;
// the back stage parses one queued byte per cycle, but a final byte waits for a free
// result register, and loads the summary into it when popped. The queue absorbs up
// to four bytes while out_stall holds the result register; beyond that in_stall
// rises. default_mss resets to 536; the user must write it with cfg_wr_en only while
// no option area is in flight, and the block itself does not enforce this.
module tcp_option_parser (
    input  wire logic        clk,
    input  wire logic        rst_n,
    // configuration
    input  wire logic        cfg_wr_en,
    input  wire logic [15:0] cfg_wr_data,
    // input channel
    input  wire logic        in_valid,
    output logic             in_stall,
    input  wire logic [7:0]  opt_byte,
    input  wire logic        last,
    // result channel
    output logic             out_valid,
    input  wire logic        out_stall,
    output logic [15:0]      kinds_seen,
    output logic [15:0]      mss,
    output logic             mss_found,
    output logic [7:0]       window_scale,
    output logic             ts_found,
    output logic [31:0]      ts_value,
    output logic [31:0]      ts_echo,
    output logic             malformed
);
    import tcpop_pkg::*;

    logic [15:0] default_mss_reg;
    logic        q_valid;
    logic        q_pop;
    q_entry_t    q_entry;
    result_t     result;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            default_mss_reg <= RESET_MSS;
        end
        else if (cfg_wr_en)
        begin
            default_mss_reg <= cfg_wr_data;
        end
    end

    // classify and queue
    tcpop_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .opt_byte (opt_byte),
        .last     (last),
        .q_pop    (q_pop),
        .q_valid  (q_valid),
        .q_entry  (q_entry)
    );

    // parse and hold the summary
    tcpop_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .q_valid     (q_valid),
        .q_entry     (q_entry),
        .q_pop       (q_pop),
        .default_mss (default_mss_reg),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .result      (result)
    );

    assign kinds_seen   = result.kinds_seen;
    assign mss          = result.mss;
    assign mss_found    = result.mss_found;
    assign window_scale = result.window_scale;
    assign ts_found     = result.ts_found;
    assign ts_value     = result.ts_value;
    assign ts_echo      = result.ts_echo;
    assign malformed    = result.malformed;

endmodule

`default_nettype wire
